// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Both forms take a label, the clock,
// the active-low reset, an antecedent and a consequent.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GORF_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");
`define GORF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");
`else
`define GORF_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define GORF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/gorf_pkg.sv
package gorf_pkg;

    localparam int ELEV_W     = 16;
    localparam int FW_W       = 9;
    localparam int FH_W       = 12;
    localparam int TH_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int SUM_W      = ELEV_W + 3;
    localparam int CMP_W      = ELEV_W + 6;
    localparam int MIN_DIM    = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD    = 2'd2;

    localparam logic [FW_W-1:0] RESET_FRAME_WIDTH  = 9'd210;
    localparam logic [FH_W-1:0] RESET_FRAME_HEIGHT = 12'd420;
    localparam logic [TH_W-1:0] RESET_THRESHOLD    = 16'd1000;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_DRAIN  = 1'b1;

    typedef logic signed [ELEV_W-1:0] elev_t;

    // Per-item decisions made when the transaction is accepted.
    typedef struct packed {
        logic drain;
        logic emit;
        logic judge;
        logic drain_first;
        logic last;
    } gorf_ctl_t;

endpackage

// File: hw/rtl/gorf_if.sv
interface gorf_in_if
    import gorf_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  kind;
    elev_t elevation;

    modport source (output valid, kind, elevation, input ready);
    modport sink (input valid, kind, elevation, output ready);
endinterface

interface gorf_out_if
    import gorf_pkg::*;
();
    logic  valid;
    logic  ready;
    elev_t cleaned;
    logic  replaced;
    logic  frame_last;

    modport source (output valid, cleaned, replaced, frame_last, input ready);
    modport sink (input valid, cleaned, replaced, frame_last, output ready);
endinterface

// File: hw/rtl/gorf_row_ram.sv
module gorf_row_ram
    import gorf_pkg::*;
#(
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  elev_t         wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output elev_t         rdata
);

    elev_t mem [DEPTH];
    elev_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hw/rtl/gorf_ctrl.sv
module gorf_ctrl
    import gorf_pkg::*;
#(
    parameter int MAX_WIDTH = 256,
    parameter int CW        = $clog2(MAX_WIDTH),
    parameter int WW        = $clog2(MAX_WIDTH + 1)
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            restart,
    input  logic [FW_W-1:0] frame_width,
    input  logic [FH_W-1:0] frame_height,
    input  logic            accept,
    input  logic            kind,
    output gorf_ctl_t       ctl,
    output logic            live,
    output logic [CW-1:0]   rd_addr
);

    logic [CW-1:0]   col_reg, col_next;
    logic [FH_W-1:0] row_reg, row_next;
    logic [WW-1:0]   drain_reg, drain_next;

    logic [WW-1:0]   eff_w;
    logic [FH_W-1:0] eff_h;
    logic [WW-1:0]   drain_dec;
    logic            col_last;
    logic            drain_last;

    always_comb
    begin
        if (32'(frame_width) < 32'(MIN_DIM))
        begin
            eff_w = WW'(MIN_DIM);
        end
        else if (32'(frame_width) > 32'(MAX_WIDTH))
        begin
            eff_w = WW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = WW'(frame_width);
        end
        eff_h = (frame_height < FH_W'(MIN_DIM)) ? FH_W'(MIN_DIM) : frame_height;
    end

    assign col_last   = (WW'(col_reg) == (eff_w - WW'(1)));
    assign drain_last = (drain_reg == eff_w);
    assign drain_dec  = drain_reg - WW'(1);

    always_comb
    begin
        ctl.drain       = (kind == KIND_DRAIN);
        ctl.emit        = ctl.drain || (row_reg >= FH_W'(2))
                          || ((row_reg == FH_W'(1)) && (col_reg != '0));
        ctl.judge       = !ctl.drain && (row_reg >= FH_W'(2)) && (col_reg >= CW'(2));
        ctl.drain_first = ctl.drain && (drain_reg == '0);
        ctl.last        = ctl.drain && drain_last;
        // Samples count only while the grid is incomplete; drain ticks only after.
        live            = ctl.drain ? (row_reg >= eff_h) : (row_reg < eff_h);
        rd_addr         = ctl.drain ? drain_dec[CW-1:0] : col_reg;
    end

    always_comb
    begin
        col_next   = col_reg;
        row_next   = row_reg;
        drain_next = drain_reg;
        priority if (restart)
        begin
            col_next   = '0;
            row_next   = '0;
            drain_next = '0;
        end
        else if (accept && live)
        begin
            if (ctl.drain)
            begin
                if (drain_last)
                begin
                    col_next   = '0;
                    row_next   = '0;
                    drain_next = '0;
                end
                else
                begin
                    drain_next = drain_reg + WW'(1);
                end
            end
            else if (col_last)
            begin
                col_next = '0;
                row_next = row_reg + FH_W'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            drain_reg <= '0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            drain_reg <= drain_next;
        end
    end

endmodule

// File: hw/rtl/gorf_window.sv
module gorf_window
    import gorf_pkg::*;
(
    input  logic            clk,
    input  logic            shift,
    input  elev_t           upper_in,
    input  elev_t           middle_in,
    input  elev_t           lower_in,
    input  logic [TH_W-1:0] threshold,
    input  logic            judge,
    output elev_t           centre,
    output elev_t           cleaned,
    output logic            replaced
);

    // The two most recent columns; with the incoming column they form the
    // 3x3 window.
    elev_t win_p1_reg [3];
    elev_t win_p2_reg [3];

    logic signed [SUM_W-1:0] nb_sum;
    logic signed [SUM_W:0]   mean_full;
    logic signed [CMP_W-1:0] sum_ext;
    logic signed [CMP_W-1:0] centre_ext;
    logic signed [CMP_W-1:0] thr_ext;
    logic signed [CMP_W-1:0] hi_lim;
    logic signed [CMP_W-1:0] lo_lim;
    logic                    outlier;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            win_p1_reg[0] <= win_p2_reg[0];
            win_p1_reg[1] <= win_p2_reg[1];
            win_p1_reg[2] <= win_p2_reg[2];
            win_p2_reg[0] <= upper_in;
            win_p2_reg[1] <= middle_in;
            win_p2_reg[2] <= lower_in;
        end
    end

    assign centre = win_p2_reg[1];

    always_comb
    begin
        nb_sum = SUM_W'(win_p1_reg[0]) + SUM_W'(win_p2_reg[0]) + SUM_W'(upper_in)
               + SUM_W'(win_p1_reg[1]) + SUM_W'(middle_in)
               + SUM_W'(win_p1_reg[2]) + SUM_W'(win_p2_reg[2]) + SUM_W'(lower_in);
        sum_ext    = CMP_W'(nb_sum);
        centre_ext = CMP_W'(centre);
        thr_ext    = $signed(CMP_W'(threshold));
        hi_lim     = (centre_ext + thr_ext) <<< 3;
        lo_lim     = (centre_ext - thr_ext) <<< 3;
        outlier    = (sum_ext > hi_lim) || (sum_ext < lo_lim);
        // Mean rounded toward plus infinity.
        mean_full  = (($bits(mean_full))'(nb_sum) + ($bits(mean_full))'(7)) >>> 3;
        replaced   = judge && outlier;
        cleaned    = replaced ? mean_full[ELEV_W-1:0] : centre;
    end

endmodule

// File: hw/rtl/grid_outlier_replace_filter.sv
// Raster-order 3x3 outlier filter for elevation grids. One transaction is
// accepted per clock cycle unless a result waits on a full, unread output
// register. A result passes from the stage register and the registered read
// of the two row-buffer RAMs (MAX_WIDTH entries each, one read and one write
// port) through one compute stage to the output register. Results trail the
// input by one row plus one cell, so after the last sample of a grid the user
// sends drain ticks, one per pending cell (the clamped frame_width plus one),
// and the final one is marked frame_last. Writing frame_width or frame_height
// restarts the grid; the row buffers need no clearing after reset.
`include "assert_macros.svh"

module grid_outlier_replace_filter
    import gorf_pkg::*;
#(
    parameter int MAX_WIDTH = 256
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    gorf_in_if.sink               samples,
    gorf_out_if.source            results,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0] frame_width_reg;
    logic [FH_W-1:0] frame_height_reg;
    logic [TH_W-1:0] threshold_reg;
    logic            restart;

    logic            in_accept;
    gorf_ctl_t       acc_ctl;
    logic            acc_live;
    logic [CW-1:0]   rd_addr;

    logic            stg_valid_reg, stg_valid_next;
    gorf_ctl_t       stg_ctl_reg;
    elev_t           stg_elev_reg;
    logic [CW-1:0]   stg_addr_reg;
    logic            stg_adv;
    logic            stg_wr;

    elev_t           up_rdata;
    elev_t           mid_rdata;
    elev_t           win_centre;
    elev_t           win_cleaned;
    logic            win_replaced;

    logic            out_valid_reg, out_valid_next;
    elev_t           out_cleaned_reg, out_cleaned_next;
    logic            out_replaced_reg, out_replaced_next;
    logic            out_last_reg, out_last_next;
    logic            out_load;

    // Configuration registers.
    assign restart = cfg_we && ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            threshold_reg    <= RESET_THRESHOLD;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_FRAME_WIDTH)
            begin
                frame_width_reg <= cfg_data[FW_W-1:0];
            end
            if (cfg_index == CFG_FRAME_HEIGHT)
            begin
                frame_height_reg <= cfg_data[FH_W-1:0];
            end
            if (cfg_index == CFG_THRESHOLD)
            begin
                threshold_reg <= cfg_data[TH_W-1:0];
            end
        end
    end

    gorf_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .CW        (CW),
        .WW        (WW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .accept       (in_accept),
        .kind         (samples.kind),
        .ctl          (acc_ctl),
        .live         (acc_live),
        .rd_addr      (rd_addr)
    );

    // The stage moves on when it has no result or the output register frees up.
    assign stg_adv       = stg_valid_reg
                           && (!stg_ctl_reg.emit || !out_valid_reg || results.ready);
    assign samples.ready = !stg_valid_reg || stg_adv;
    assign in_accept     = samples.valid && samples.ready;
    assign stg_wr        = stg_adv && !stg_ctl_reg.drain;

    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (in_accept)
        begin
            stg_valid_next = acc_live;
        end
        else if (stg_adv)
        begin
            stg_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            stg_ctl_reg   <= '0;
        end
        else
        begin
            stg_valid_reg <= stg_valid_next;
            if (in_accept)
            begin
                stg_ctl_reg <= acc_ctl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stg_elev_reg <= samples.elevation;
            stg_addr_reg <= rd_addr;
        end
    end

    gorf_row_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_upper (
        .clk   (clk),
        .we    (stg_wr),
        .waddr (stg_addr_reg),
        .wdata (mid_rdata),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (up_rdata)
    );

    gorf_row_ram #(
        .DEPTH (MAX_WIDTH),
        .AW    (CW)
    ) u_ram_middle (
        .clk   (clk),
        .we    (stg_wr),
        .waddr (stg_addr_reg),
        .wdata (stg_elev_reg),
        .re    (in_accept),
        .raddr (rd_addr),
        .rdata (mid_rdata)
    );

    gorf_window u_window (
        .clk       (clk),
        .shift     (stg_wr),
        .upper_in  (up_rdata),
        .middle_in (mid_rdata),
        .lower_in  (stg_elev_reg),
        .threshold (threshold_reg),
        .judge     (stg_ctl_reg.judge),
        .centre    (win_centre),
        .cleaned   (win_cleaned),
        .replaced  (win_replaced)
    );

    // Output register.
    assign out_load = stg_adv && stg_ctl_reg.emit;

    always_comb
    begin
        out_valid_next    = out_valid_reg;
        out_cleaned_next  = out_cleaned_reg;
        out_replaced_next = out_replaced_reg;
        out_last_next     = out_last_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
            if (stg_ctl_reg.drain)
            begin
                // The first drain tick returns the right edge of the middle row.
                out_cleaned_next  = stg_ctl_reg.drain_first ? win_centre : mid_rdata;
                out_replaced_next = 1'b0;
                out_last_next     = stg_ctl_reg.last;
            end
            else
            begin
                out_cleaned_next  = win_cleaned;
                out_replaced_next = win_replaced;
                out_last_next     = 1'b0;
            end
        end
        else if (results.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_cleaned_reg  <= out_cleaned_next;
        out_replaced_reg <= out_replaced_next;
        out_last_reg     <= out_last_next;
    end

    assign results.valid      = out_valid_reg;
    assign results.cleaned    = out_cleaned_reg;
    assign results.replaced   = out_replaced_reg;
    assign results.frame_last = out_last_reg;

    `GORF_ASSERT_NEXT(a_stage_holds, clk, rst_n, stg_valid_reg && !stg_adv, stg_valid_reg && $stable(stg_elev_reg))
    `GORF_ASSERT_NEXT(a_emit_loads, clk, rst_n, out_load, out_valid_reg)
    `GORF_ASSERT_IMPL(a_last_unreplaced, clk, rst_n, out_valid_reg && out_last_reg, !out_replaced_reg)
    `GORF_ASSERT_IMPL(a_ram_no_collide, clk, rst_n, in_accept && !acc_ctl.drain_first && stg_wr, rd_addr != stg_addr_reg)

endmodule
